>>> rtl/lrtr_pkg.sv
// Package for the luminance ratio tile recolour block: types, widths and colour tables.
package lrtr_pkg;

  // Field and datapath widths
  localparam int unsigned PosW      = 12;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned TileSizeW = 10;
  localparam int unsigned WidthW    = 13;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 13;
  localparam int unsigned TileCnt   = 8;
  localparam int unsigned TileW     = 3;
  localparam int unsigned ChanCnt   = 3;
  localparam int unsigned LumW      = 18;   // full white is 261120
  localparam int unsigned ProdW     = 26;   // target * lum < 2^26
  localparam int unsigned RecipW    = 10;
  localparam int unsigned RecipShift = ProdW;
  localparam int unsigned QuotW     = RecipW;

  // Widest usable image; wider settings are clamped to this
  localparam int unsigned MaxDimension = 4096;

  // Reset values of the registers
  localparam logic [TileSizeW-1:0] TileSizeRst   = 10'd16;
  localparam logic [WidthW-1:0]    ImageWidthRst = 13'd128;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgTileSize   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgImageWidth = 1'b1;

  // Luminance weights, units of 1/1024
  localparam logic [LumW-1:0] LumR = 18'd306;
  localparam logic [LumW-1:0] LumG = 18'd601;
  localparam logic [LumW-1:0] LumB = 18'd117;

  typedef logic [ChanW-1:0] chan_t;

  // Colour-blind target colours per tile, red/green/blue
  localparam chan_t TargetRgb [TileCnt][ChanCnt] = '{
    '{8'd0,   8'd114, 8'd178},
    '{8'd204, 8'd121, 8'd167},
    '{8'd213, 8'd94,  8'd0},
    '{8'd0,   8'd158, 8'd115},
    '{8'd240, 8'd228, 8'd66},
    '{8'd86,  8'd180, 8'd233},
    '{8'd230, 8'd159, 8'd0},
    '{8'd0,   8'd114, 8'd178}
  };

  // Weighted luminance of each tile's normal colour. All lie well above 1.0,
  // so the lower clamp of the base never takes effect.
  localparam logic [LumW-1:0] TileBase [TileCnt] = '{
    18'd124831, 18'd129707, 18'd97803,  18'd150800,
    18'd199076, 18'd155671, 18'd151247, 18'd124831
  };

  // floor(2^26 / base): quotient estimate is then exact or one low
  localparam logic [RecipW-1:0] TileRecip [TileCnt] = '{
    10'd537, 10'd517, 10'd686, 10'd445,
    10'd337, 10'd431, 10'd443, 10'd537
  };

  typedef struct packed {
    logic [PosW-1:0]  pos_x;
    logic [PosW-1:0]  pos_y;
    logic [ChanW-1:0] in_red;
    logic [ChanW-1:0] in_green;
    logic [ChanW-1:0] in_blue;
    logic [ChanW-1:0] in_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_alpha;
  } pix_out_t;

endpackage

>>> rtl/luminance_ratio_tile_recolor.sv
// Throughput: one item per cycle when the output is not stalled; five register stages
// (tile decode and luminance, target multiply, reciprocal multiply, back multiply,
// correction and saturation).
// Stages with no item are filled while the output is stalled.
// Reset clears all valid bits and sets tile_size to 16 and image_width to 128.
module luminance_ratio_tile_recolor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  lrtr_pkg::pix_in_t               in_pix_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output lrtr_pkg::pix_out_t              out_pix_o,
  input  logic                            cfg_we_i,
  input  logic [lrtr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [lrtr_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import lrtr_pkg::*;

  // Configuration registers
  logic [TileSizeW-1:0] tile_size_q;
  logic [WidthW-1:0]    image_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_size_q   <= TileSizeRst;
      image_width_q <= ImageWidthRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTileSize:   tile_size_q   <= cfg_wdata_i[TileSizeW-1:0];
        CfgImageWidth: image_width_q <= cfg_wdata_i[WidthW-1:0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage moves when it is empty or the next one moves
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || out_ready_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // ---------------- Stage 1: tile decode and luminance ----------------
  logic [WidthW-1:0] ts_mult [TileCnt+1];
  logic [WidthW-1:0] width_eff;
  logic [TileCnt-1:0] tile_fits;
  logic [TileW-1:0]  tile_d;
  logic              inside_strip;
  logic              recolor_d;
  logic [LumW-1:0]   lum_d;
  pix_out_t          pass_d;

  always_comb begin
    // clamp of the width
    if (32'(image_width_q) > MaxDimension) begin
      width_eff = WidthW'(MaxDimension);
    end else begin
      width_eff = image_width_q;
    end
    // tile edges k * tile_size
    for (int k = 0; k <= TileCnt; k++) begin
      ts_mult[k] = WidthW'(k) * WidthW'(tile_size_q);
    end
    // whole tile k within the width
    for (int k = 0; k < TileCnt; k++) begin
      tile_fits[k] = ts_mult[k+1] <= width_eff;
    end
    // tile index among 0..7 by edge compare
    tile_d = '0;
    for (int k = 1; k < TileCnt; k++) begin
      if (WidthW'(in_pix_i.pos_x) >= ts_mult[k]) tile_d = TileW'(k);
    end
    inside_strip = WidthW'(in_pix_i.pos_x) < ts_mult[TileCnt];
    recolor_d = inside_strip && (tile_d != '0) && tile_fits[tile_d] &&
                (in_pix_i.pos_y < PosW'(tile_size_q));
    lum_d = LumR * LumW'(in_pix_i.in_red) + LumG * LumW'(in_pix_i.in_green) +
            LumB * LumW'(in_pix_i.in_blue);
    pass_d.out_red   = in_pix_i.in_red;
    pass_d.out_green = in_pix_i.in_green;
    pass_d.out_blue  = in_pix_i.in_blue;
    pass_d.out_alpha = in_pix_i.in_alpha;
  end

  logic [TileW-1:0] tile1_q;
  logic             rec1_q;
  logic [LumW-1:0]  lum1_q;
  pix_out_t         pix1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      tile1_q <= tile_d;
      rec1_q  <= recolor_d;
      lum1_q  <= lum_d;
      pix1_q  <= pass_d;
    end
  end

  // ---------------- Stage 2: target * luminance ----------------
  logic [TileW-1:0] tile2_q;
  logic             rec2_q;
  logic [ProdW-1:0] prod2_q [ChanCnt];
  pix_out_t         pix2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      tile2_q <= tile1_q;
      rec2_q  <= rec1_q;
      pix2_q  <= pix1_q;
      for (int c = 0; c < ChanCnt; c++) begin
        prod2_q[c] <= ProdW'(TargetRgb[tile1_q][c]) * ProdW'(lum1_q);
      end
    end
  end

  // ---------------- Stage 3: quotient estimate by reciprocal ----------------
  logic [ProdW+RecipW-1:0] est_full [ChanCnt];

  always_comb begin
    for (int c = 0; c < ChanCnt; c++) begin
      est_full[c] = (ProdW+RecipW)'(prod2_q[c]) * (ProdW+RecipW)'(TileRecip[tile2_q]);
    end
  end

  logic [TileW-1:0] tile3_q;
  logic             rec3_q;
  logic [ProdW-1:0] prod3_q [ChanCnt];
  logic [QuotW-1:0] qe3_q [ChanCnt];
  pix_out_t         pix3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      tile3_q <= tile2_q;
      rec3_q  <= rec2_q;
      pix3_q  <= pix2_q;
      for (int c = 0; c < ChanCnt; c++) begin
        prod3_q[c] <= prod2_q[c];
        qe3_q[c]   <= est_full[c][ProdW+RecipW-1:RecipShift];
      end
    end
  end

  // ---------------- Stage 4: estimate * base ----------------
  logic [QuotW+LumW-1:0] back_full [ChanCnt];

  always_comb begin
    for (int c = 0; c < ChanCnt; c++) begin
      back_full[c] = (QuotW+LumW)'(qe3_q[c]) * (QuotW+LumW)'(TileBase[tile3_q]);
    end
  end

  logic [TileW-1:0] tile4_q;
  logic             rec4_q;
  logic [ProdW-1:0] prod4_q [ChanCnt];
  logic [ProdW-1:0] back4_q [ChanCnt];
  logic [QuotW-1:0] qe4_q [ChanCnt];
  pix_out_t         pix4_q;

  // estimate never exceeds the true quotient, so back product fits ProdW
  always_ff @(posedge clk_i) begin
    if (en4) begin
      tile4_q <= tile3_q;
      rec4_q  <= rec3_q;
      pix4_q  <= pix3_q;
      for (int c = 0; c < ChanCnt; c++) begin
        prod4_q[c] <= prod3_q[c];
        back4_q[c] <= back_full[c][ProdW-1:0];
        qe4_q[c]   <= qe3_q[c];
      end
    end
  end

  // ---------------- Stage 5: correction, saturation, output register ----------------
  logic [ProdW-1:0] rem [ChanCnt];
  logic [QuotW:0]   quot [ChanCnt];
  chan_t            sat [ChanCnt];
  pix_out_t         out_d;
  pix_out_t         out_pix_q;

  always_comb begin
    for (int c = 0; c < ChanCnt; c++) begin
      rem[c]  = prod4_q[c] - back4_q[c];
      quot[c] = {1'b0, qe4_q[c]} + (QuotW+1)'(rem[c] >= ProdW'(TileBase[tile4_q]));
      sat[c]  = (quot[c] > (QuotW+1)'(255)) ? 8'd255 : quot[c][ChanW-1:0];
    end
    out_d = pix4_q;
    if (rec4_q) begin
      out_d.out_red   = sat[0];
      out_d.out_green = sat[1];
      out_d.out_blue  = sat[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      out_pix_q <= out_d;
    end
  end

  assign out_valid_o = v5_q;
  assign out_pix_o   = out_pix_q;

endmodule

>>> rtl/lrtr_checker.sv
// Port-level checks for the luminance ratio tile recolour block, bound to the top level.
module lrtr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input lrtr_pkg::pix_out_t out_pix_o
);

  // a stalled result item stays and holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_pix_o))
    else $error("result item changed or dropped while stalled");

  // with the output register empty nothing can block the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input refused with an empty output register");

  // a result being taken frees the whole pipeline for a new item
  a_ready_on_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |-> in_ready_o)
    else $error("input refused while the result item is taken");

endmodule

bind luminance_ratio_tile_recolor lrtr_checker u_lrtr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_pix_o   (out_pix_o)
);

>>> bench/recolour_checker.sv
// Checker for the tile recolour block: predicts each pixel and compares the results.
module recolour_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  lrtr_pkg::pix_in_t             in_pix_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  lrtr_pkg::pix_out_t            out_pix_i,
  input  logic                          cfg_we_i,
  input  logic [lrtr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lrtr_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int unsigned                   fail_cnt_o,
  output int unsigned                   pending_o,
  output int unsigned                   recoloured_o
);
  import lrtr_pkg::*;

  // Luminance weights in units of 1/1024, and the floor of the base luminance
  localparam int unsigned WeightRed   = 306;
  localparam int unsigned WeightGreen = 601;
  localparam int unsigned WeightBlue  = 117;
  localparam int unsigned UnitLuma    = 1024;
  localparam int unsigned WidthCap    = 4096;

  // Normal colour of each tile and the colour-blind colour that replaces it
  localparam int unsigned NormalRgb [8][3] = '{
    '{62, 130, 237}, '{142, 104, 203}, '{219, 45, 32}, '{102, 191, 41},
    '{244, 200, 36}, '{48, 190, 229}, '{235, 125, 36}, '{62, 130, 237}
  };
  localparam int unsigned TargetColour [8][3] = '{
    '{0, 114, 178}, '{204, 121, 167}, '{213, 94, 0}, '{0, 158, 115},
    '{240, 228, 66}, '{86, 180, 233}, '{230, 159, 0}, '{0, 114, 178}
  };

  // Shadow copy of the registers
  logic [TileSizeW-1:0] tile_size;
  logic [WidthW-1:0]    image_width;

  pix_out_t    expected_pixels [$];
  int unsigned mismatches;
  int unsigned recoloured;

  function automatic int unsigned weigh_luma(int unsigned r, int unsigned g, int unsigned b);
    weigh_luma = WeightRed * r + WeightGreen * g + WeightBlue * b;
  endfunction

  function automatic logic [ChanW-1:0] clip_channel(int unsigned v);
    clip_channel = (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // True when the pixel lies in a whole tile 1..7 within the width and above the tile edge
  function automatic bit in_recolour_tile(pix_in_t p, output int unsigned tile);
    int unsigned ts, width, x, y;
    ts    = tile_size;
    width = (image_width > WidthCap) ? WidthCap : image_width;
    x     = p.pos_x;
    y     = p.pos_y;
    tile  = 0;
    in_recolour_tile = 1'b0;
    if (ts != 0) begin
      tile = x / ts;
      in_recolour_tile = (tile >= 1) && (tile <= 7) && ((tile + 1) * ts <= width) && (y < ts);
    end
  endfunction

  function automatic pix_out_t recolour_pixel(pix_in_t p);
    int unsigned tile, lum, base;
    pix_out_t r;
    r.out_red   = p.in_red;
    r.out_green = p.in_green;
    r.out_blue  = p.in_blue;
    r.out_alpha = p.in_alpha;
    if (in_recolour_tile(p, tile)) begin
      lum  = weigh_luma(p.in_red, p.in_green, p.in_blue);
      base = weigh_luma(NormalRgb[tile][0], NormalRgb[tile][1], NormalRgb[tile][2]);
      if (base < UnitLuma) base = UnitLuma;
      r.out_red   = clip_channel(TargetColour[tile][0] * lum / base);
      r.out_green = clip_channel(TargetColour[tile][1] * lum / base);
      r.out_blue  = clip_channel(TargetColour[tile][2] * lum / base);
    end
    recolour_pixel = r;
  endfunction

  task automatic check_channel(input string name, input logic [ChanW-1:0] want,
                               input logic [ChanW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Track register writes, predict accepted items and match results in order
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned tile;
    pix_out_t    want;
    if (!rst_ni) begin
      expected_pixels.delete();
      tile_size    = TileSizeRst;
      image_width  = ImageWidthRst;
      mismatches   = 0;
      recoloured   = 0;
      fail_cnt_o   <= 0;
      pending_o    <= 0;
      recoloured_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgTileSize) tile_size = cfg_wdata_i[TileSizeW-1:0];
        else if (cfg_idx_i == CfgImageWidth) image_width = cfg_wdata_i;
      end
      // results first, so an item accepted on this edge cannot match
      if (out_valid_i && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: result with none expected, got %h", $time, out_pix_i);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          check_channel("out_red", want.out_red, out_pix_i.out_red);
          check_channel("out_green", want.out_green, out_pix_i.out_green);
          check_channel("out_blue", want.out_blue, out_pix_i.out_blue);
          check_channel("out_alpha", want.out_alpha, out_pix_i.out_alpha);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_pixels.push_back(recolour_pixel(in_pix_i));
        if (in_recolour_tile(in_pix_i, tile)) recoloured++;
      end
      fail_cnt_o   <= mismatches;
      pending_o    <= expected_pixels.size();
      recoloured_o <= recoloured;
    end
  end

endmodule

>>> bench/luminance_ratio_tile_recolor_test.sv
// Testbench top for the tile recolour block: stimulus, register settings and verdict.
module luminance_ratio_tile_recolor_test;
  import lrtr_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned LongHold    = 50;
  localparam int unsigned PhaseItems  = 135;
  localparam int unsigned FixedCnt    = 7;
  localparam int unsigned PhaseCnt    = 14;
  localparam int unsigned HoldPhase   = 2;
  localparam int unsigned HoldItems   = 60;

  // Fixed settings: reset values, smallest tile, largest fit, zero tile, clamped width,
  // partial fit, zero width
  localparam int unsigned FixedTs [FixedCnt]    = '{16, 1, 512, 0, 1023, 64, 7};
  localparam int unsigned FixedWidth [FixedCnt] = '{128, 8, 4096, 4096, 8191, 300, 0};

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  pix_in_t             in_pix;
  logic                out_valid;
  logic                out_ready;
  pix_out_t            out_pix;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned recoloured;
  int unsigned sent_cnt   = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned hold_req   = 0;
  bit          quiet      = 1'b0;

  always #5 clk = ~clk;

  luminance_ratio_tile_recolor DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_pix_i    (in_pix),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_pix_o   (out_pix),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  recolour_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_pix_i     (in_pix),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_pix_i    (out_pix),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending),
    .recoloured_o (recoloured)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("luminance_ratio_tile_recolor regression: fail");
      $finish;
    end
  end

  function automatic pix_in_t pixel_at(int unsigned x, int unsigned y, int unsigned r,
                                       int unsigned g, int unsigned b, int unsigned a);
    pix_in_t p;
    p.pos_x    = x[PosW-1:0];
    p.pos_y    = y[PosW-1:0];
    p.in_red   = r[ChanW-1:0];
    p.in_green = g[ChanW-1:0];
    p.in_blue  = b[ChanW-1:0];
    p.in_alpha = a[ChanW-1:0];
    pixel_at = p;
  endfunction

  // Channel value, with the extremes favoured
  function automatic int unsigned pick_channel();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) pick_channel = 0;
    else if (pick == 1) pick_channel = 255;
    else pick_channel = $urandom_range(0, 255);
  endfunction

  // Mostly pixels in tiles 1..7 above the edge; else anywhere, in tile zero or just below it
  function automatic pix_in_t random_pixel(int unsigned ts);
    int unsigned pick, tile, x, y;
    pick = $urandom_range(0, 9);
    x    = $urandom_range(0, 4095);
    y    = $urandom_range(0, 4095);
    if (pick < 7 && ts != 0) begin
      tile = $urandom_range(1, 7);
      if (tile * ts + ts - 1 <= 4095) x = tile * ts + $urandom_range(0, ts - 1);
      y = (pick == 6) ? ts + $urandom_range(0, 2) : $urandom_range(0, ts - 1);
      if (y > 4095) y = 4095;
    end else if (pick == 7 && ts != 0) begin
      x = $urandom_range(0, (ts < 4096) ? ts - 1 : 4095);
    end
    random_pixel = pixel_at(x, y, pick_channel(), pick_channel(), pick_channel(),
                            pick_channel());
  endfunction

  // Offer one item and wait for it to be taken; sometimes idle afterwards
  task automatic send_pixel(input pix_in_t p, input bit may_idle);
    in_pix   <= p;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent_cnt++;
    if (may_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every outstanding result has come back
  task automatic settle_block();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: random stall bursts, one long hold on request, none at the end
  initial begin : drain_side
    int unsigned hold_seen;
    hold_seen = 0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Stimulus
  initial begin : feed_side
    int unsigned phase, n, ts, wd;
    logic [2:0]  spare;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_pix    <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CfgTileSize;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (phase = 0; phase < PhaseCnt; phase++) begin
      spare = 3'd0;
      if (phase < FixedCnt) begin
        ts = FixedTs[phase];
        wd = FixedWidth[phase];
      end else begin
        ts    = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(9, 600);
        wd    = $urandom_range(0, 1) ? ts * $urandom_range(2, 8) - $urandom_range(0, 1)
                                     : $urandom_range(0, 8191);
        if (wd > 8191) wd = 8191;
        spare = 3'($urandom_range(0, 7));   // upper write bits that tile_size drops
      end

      if (phase == 0) begin
        // Directed items under the reset setting (16-pixel tiles, 128 wide)
        for (n = 0; n <= 8; n++) send_pixel(pixel_at(n * 16, 0, 255, 255, 255, 255), 1'b1);
        for (n = 1; n <= 7; n++) send_pixel(pixel_at(n * 16 + 15, 15, 0, 0, 0, 0), 1'b1);
        send_pixel(pixel_at(16, 16, 200, 100, 50, 128), 1'b1);   // row on the tile edge
        send_pixel(pixel_at(4095, 4095, 255, 0, 255, 1), 1'b1);  // far corner
        send_pixel(pixel_at(64, 3, 255, 0, 0, 7), 1'b1);
        send_pixel(pixel_at(80, 9, 0, 255, 0, 9), 1'b1);
        send_pixel(pixel_at(33, 5, 0, 0, 255, 200), 1'b1);
        send_pixel(pixel_at(15, 15, 128, 128, 128, 64), 1'b1);   // last pixel of tile zero
      end else begin
        settle_block();
        write_reg(CfgTileSize, {spare, ts[TileSizeW-1:0]});
        write_reg(CfgImageWidth, wd[WidthW-1:0]);
      end

      if (phase == HoldPhase) hold_req <= hold_req + 1;
      if (phase == PhaseCnt - 1) quiet <= 1'b1;
      for (n = 0; n < PhaseItems; n++)
        send_pixel(random_pixel(ts),
                   (phase != PhaseCnt - 1) && !(phase == HoldPhase && n < HoldItems));
    end
    settle_block();

    $display("Covered %0d pixels over %0d register settings, %0d of them recoloured,",
             sent_cnt, PhaseCnt, recoloured);
    $display("with zero and largest tile sizes, zero and clamped widths, and a long output stall.");
    if (fail_cnt == 0) begin
      $display("luminance_ratio_tile_recolor regression: pass");
    end else begin
      $display("luminance_ratio_tile_recolor regression: fail");
    end
    $finish;
  end

endmodule

>>> luminance_ratio_tile_recolor.f
rtl/lrtr_pkg.sv
rtl/luminance_ratio_tile_recolor.sv
rtl/lrtr_checker.sv
bench/recolour_checker.sv
bench/luminance_ratio_tile_recolor_test.sv
